>>> hdl/mbf_pkg.sv
// ----------------------------------------------------------------------------
// mbf_pkg
// Shared types and constants of the box-filter mip generator.
// ----------------------------------------------------------------------------
package mbf_pkg;

    localparam int MAX_BOX_DEF    = 2048;
    localparam int MAX_LEVELS_DEF = 12;

    localparam int CH_W     = 8;
    localparam int TEXEL_W  = 4 * CH_W;
    localparam int WIDTH_W  = 12;
    localparam int POS_W    = 11;
    localparam int LVL_W    = 4;
    localparam int DIM_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_LEFT   = 3'd2,
        CFG_TOP    = 3'd3,
        CFG_LEVELS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [WIDTH_W-1:0] height;
        logic [POS_W-1:0]   left;
        logic [POS_W-1:0]   top;
        logic [LVL_W-1:0]   levels;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        width:  WIDTH_W'(2048),
        height: WIDTH_W'(2048),
        left:   '0,
        top:    '0,
        levels: LVL_W'(1)
    };

endpackage

>>> hdl/mbf_texel_if.sv
// ----------------------------------------------------------------------------
// mbf_texel_if
// Input channel: one RGBA texel per word.
// ----------------------------------------------------------------------------
interface mbf_texel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

>>> hdl/mbf_result_if.sv
// ----------------------------------------------------------------------------
// mbf_result_if
// Output channel: one averaged mip texel per word.
// ----------------------------------------------------------------------------
interface mbf_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  level;
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [7:0]  avg_alpha;
    logic        last;

    modport source (output valid, level, dest_x, dest_y, avg_red, avg_green, avg_blue,
                    avg_alpha, last, input ready);
    modport sink   (input valid, level, dest_x, dest_y, avg_red, avg_green, avg_blue,
                    avg_alpha, last, output ready);
endinterface

>>> hdl/mip_box_filter_stream_top.sv
// ----------------------------------------------------------------------------
// mip_box_filter_stream_top
// Streaming box-filter mip generator over a raster-order texel box.
// ----------------------------------------------------------------------------
// A texel word is taken every cycle while the bundle queue has room; each
// texel updates one accumulator per level above 0 in parallel RAM banks
// (read at accept, add and write back in the cycle after, with forwarding).
// Finished squares go through a 4-deep queue to a serializer that sends one
// result word per cycle while the output is ready. A square's accumulator
// is loaded by its first texel, so no clearing pass follows reset or a
// register write.
module mip_box_filter_stream_top import mbf_pkg::*; #(
    parameter int MAX_BOX    = MAX_BOX_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mbf_texel_if.sink             i_texel,
    mbf_result_if.source          o_mip,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW  = $clog2(MAX_BOX);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int BW  = 2 * CW + MAX_LEVELS + MAX_LEVELS * TEXEL_W;

    t_cfg           r_cfg;
    logic           restart;
    logic           q_push, q_pop, q_empty;
    logic [BW-1:0]  q_in, q_head;
    logic [QCW-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[WIDTH_W-1:0];
                CFG_LEFT:   r_cfg.left   <= i_cfg_data[POS_W-1:0];
                CFG_TOP:    r_cfg.top    <= i_cfg_data[POS_W-1:0];
                CFG_LEVELS: r_cfg.levels <= i_cfg_data[LVL_W-1:0];
                default:    ;
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_idx <= CFG_LEVELS);

    mbf_front #(.MAX_BOX(MAX_BOX), .MAX_LEVELS(MAX_LEVELS), .CW(CW), .QCW(QCW), .BW(BW))
    u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_restart(restart), .i_texel,
        .i_q_count(q_count), .o_push(q_push), .o_bundle(q_in)
    );

    mbf_queue #(.W(BW), .QCW(QCW)) u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_data(q_in), .i_pop(q_pop),
        .o_head(q_head), .o_empty(q_empty), .o_count(q_count)
    );

    mbf_back #(.MAX_LEVELS(MAX_LEVELS), .CW(CW), .BW(BW)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_head(q_head), .i_empty(q_empty),
        .o_pop(q_pop), .o_mip
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QCW'(QUEUE_DEPTH)) || q_pop)
        else $error("bundle queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("bundle queue underflow");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mip.valid |-> (o_mip.level < LVL_W'(MAX_LEVELS)))
        else $error("result level out of range");

endmodule

>>> hdl/mbf_front.sv
// ----------------------------------------------------------------------------
// mbf_front
// Position counters and per-level accumulator banks; emits a bundle of
// finished squares for each texel that finishes at least one square.
// ----------------------------------------------------------------------------
module mbf_front import mbf_pkg::*; #(
    parameter int MAX_BOX    = MAX_BOX_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int CW         = $clog2(MAX_BOX),
    parameter int QCW        = $clog2(QUEUE_DEPTH + 1),
    parameter int BW         = 2 * CW + MAX_LEVELS + MAX_LEVELS * TEXEL_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_restart,
    mbf_texel_if.sink      i_texel,
    input  logic [QCW-1:0] i_q_count,
    output logic           o_push,
    output logic [BW-1:0]  o_bundle
);

    logic [DIM_W-1:0] wd, ht;
    logic [LVL_W-1:0] lv;
    logic             dim_zero;
    logic             accept;
    logic [QCW:0]     used;

    logic [CW-1:0]    r_col, r_row;
    logic             r_p1_v;
    logic [TEXEL_W-1:0] r_px;
    logic [MAX_LEVELS-1:0] act_c, r_act, corner_c, r_corner, first_c, r_first, mask;
    logic [MAX_LEVELS-1:0][TEXEL_W-1:0] avg;
    logic [CW-1:0]    r_p1_col, r_p1_row;

    assign wd = (DIM_W'(i_cfg.width) > DIM_W'(MAX_BOX)) ? DIM_W'(MAX_BOX) : DIM_W'(i_cfg.width);
    assign ht = (DIM_W'(i_cfg.height) > DIM_W'(MAX_BOX)) ? DIM_W'(MAX_BOX)
                                                         : DIM_W'(i_cfg.height);
    assign lv = (i_cfg.levels > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : i_cfg.levels;
    assign dim_zero = (wd == '0) || (ht == '0);

    assign used          = (QCW + 1)'(i_q_count) + (QCW + 1)'(r_p1_v);
    assign i_texel.ready = used < (QCW + 1)'(QUEUE_DEPTH);
    assign accept        = i_texel.valid && i_texel.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= accept && !dim_zero;
            if (accept && !dim_zero) begin
                if (DIM_W'(r_col) + DIM_W'(1) >= wd) begin
                    r_col <= '0;
                    if (DIM_W'(r_row) + DIM_W'(1) >= ht) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + CW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px     <= {i_texel.red, i_texel.green, i_texel.blue, i_texel.alpha};
            r_act    <= act_c;
            r_corner <= corner_c;
            r_first  <= first_c;
            r_p1_col <= r_col;
            r_p1_row <= r_row;
        end
    end

    for (genvar L = 0; L < MAX_LEVELS; L++) begin : g_lvl
        localparam int DEP = MAX_BOX >> L;
        if (L == 0) begin : g_base
            assign act_c[L]    = (lv != '0);
            assign corner_c[L] = 1'b1;
            assign first_c[L]  = 1'b1;
            assign avg[L]      = r_px;
        end else if (DEP > 0) begin : g_bank
            localparam int IW = (DEP > 1) ? $clog2(DEP) : 1;
            localparam int SW = CH_W + 2 * L;
            logic [CW-1:0]   xl, yl;
            logic [IW-1:0]   r_addr, r_fwd_a;
            logic [3:0][SW-1:0] r_mem [DEP];
            logic [3:0][SW-1:0] r_rd, r_fwd_d, old, sum;
            logic            r_fwd_v, we;

            assign xl = r_col >> L;
            assign yl = r_row >> L;
            assign act_c[L] = (LVL_W'(L) < lv) && (DIM_W'(xl) < (wd >> L))
                              && (DIM_W'(yl) < (ht >> L));
            assign corner_c[L] = (&r_col[L-1:0]) && (&r_row[L-1:0]);
            assign first_c[L]  = !(|r_col[L-1:0]) && !(|r_row[L-1:0]);

            assign we  = r_p1_v && r_act[L];
            assign old = (r_fwd_v && r_fwd_a == r_addr) ? r_fwd_d : r_rd;

            always_comb begin
                for (int c = 0; c < 4; c++) begin
                    sum[c] = (r_first[L] ? SW'(0) : old[c]) + SW'(r_px[c*CH_W +: CH_W]);
                    avg[L][c*CH_W +: CH_W] = sum[c][2*L +: CH_W];
                end
            end

            always_ff @(posedge i_clk) begin
                if (accept) begin
                    r_rd   <= r_mem[xl[IW-1:0]];
                    r_addr <= xl[IW-1:0];
                end
                if (we) begin
                    r_mem[r_addr] <= sum;
                end
                r_fwd_a <= r_addr;
                r_fwd_d <= sum;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_fwd_v <= 1'b0;
                end else begin
                    r_fwd_v <= we;
                end
            end
        end else begin : g_none
            assign act_c[L]    = 1'b0;
            assign corner_c[L] = 1'b0;
            assign first_c[L]  = 1'b0;
            assign avg[L]      = '0;
        end
    end

    assign mask     = r_act & r_corner;
    assign o_push   = r_p1_v && (|mask);
    assign o_bundle = {r_p1_col, r_p1_row, mask, avg};

endmodule

>>> hdl/mbf_queue.sv
// ----------------------------------------------------------------------------
// mbf_queue
// Short bundle queue between the accumulators and the output serializer.
// ----------------------------------------------------------------------------
module mbf_queue import mbf_pkg::*; #(
    parameter int W   = 8,
    parameter int QCW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [W-1:0]   i_data,
    input  logic           i_pop,
    output logic [W-1:0]   o_head,
    output logic           o_empty,
    output logic [QCW-1:0] o_count
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [W-1:0]   r_data [QUEUE_DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [QCW-1:0] r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= bump(r_wp);
            if (i_pop)  r_rp <= bump(r_rp);
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_data[r_wp] <= i_data;
    end

    assign o_head  = r_data[r_rp];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

>>> hdl/mbf_back.sv
// ----------------------------------------------------------------------------
// mbf_back
// Serializes each bundle into result words, lowest level first.
// ----------------------------------------------------------------------------
module mbf_back import mbf_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int CW         = 11,
    parameter int BW         = 2 * CW + MAX_LEVELS + MAX_LEVELS * TEXEL_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic [BW-1:0] i_head,
    input  logic          i_empty,
    output logic          o_pop,
    mbf_result_if.source  o_mip
);

    localparam int AVG_W = MAX_LEVELS * TEXEL_W;

    logic [BW-1:0]         r_cur;
    logic [MAX_LEVELS-1:0] r_rem, rem_nx;
    logic [LVL_W-1:0]      sel;
    logic                  out_free, emit;
    logic [CW-1:0]         col, row;
    logic [TEXEL_W-1:0]    texel;
    logic                  r_ov;

    assign col = r_cur[BW-1 -: CW];
    assign row = r_cur[BW-CW-1 -: CW];

    always_comb begin
        sel = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (r_rem[i]) sel = LVL_W'(i);
        end
    end

    assign out_free = !r_ov || o_mip.ready;
    assign emit     = (|r_rem) && out_free;
    assign rem_nx   = emit ? (r_rem & ~(MAX_LEVELS'(1) << sel)) : r_rem;
    assign o_pop    = (rem_nx == '0) && !i_empty;
    assign texel    = r_cur[32'(sel) * TEXEL_W +: TEXEL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_rem <= o_pop ? i_head[AVG_W +: MAX_LEVELS] : rem_nx;
            if (out_free) r_ov <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_head;
        if (emit) begin
            o_mip.level     <= sel;
            o_mip.dest_x    <= (i_cfg.left >> sel) + POS_W'(col >> sel);
            o_mip.dest_y    <= (i_cfg.top >> sel) + POS_W'(row >> sel);
            o_mip.avg_red   <= texel[3*CH_W +: CH_W];
            o_mip.avg_green <= texel[2*CH_W +: CH_W];
            o_mip.avg_blue  <= texel[CH_W +: CH_W];
            o_mip.avg_alpha <= texel[0 +: CH_W];
            o_mip.last      <= (rem_nx == '0);
        end
    end

    assign o_mip.valid = r_ov;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming box-filter mip generator. A local
// predictor keeps its own accumulators and box position, works out the mip
// words that each accepted texel should cause, and compares them in order
// with the words that leave the block. Directed box shapes come first,
// then random boxes with random pacing and last a long output stall.
// ----------------------------------------------------------------------------
module tb import mbf_pkg::*; ();

    localparam int BOX_MAX   = 2048;
    localparam int LVL_MAX   = 12;
    localparam int ACC_SLOTS = 2 * BOX_MAX;
    localparam int LIMIT     = 400000;

    typedef struct packed {
        logic [3:0]  level;
        logic [10:0] dest_x;
        logic [10:0] dest_y;
        logic [7:0]  avg_red;
        logic [7:0]  avg_green;
        logic [7:0]  avg_blue;
        logic [7:0]  avg_alpha;
        logic        last;
    } t_mip_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mbf_texel_if  texel_ch ();
    mbf_result_if mip_ch ();

    mip_box_filter_stream_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_texel    (texel_ch.sink),
        .o_mip      (mip_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [11:0] box_w = 12'd2048, box_h = 12'd2048;
    logic [10:0] box_l = '0, box_t = '0;
    logic [3:0]  n_levels = 4'd1;
    int unsigned pos_col, pos_row;
    logic [29:0] acc_r [ACC_SLOTS];
    logic [29:0] acc_g [ACC_SLOTS];
    logic [29:0] acc_b [ACC_SLOTS];
    logic [29:0] acc_a [ACC_SLOTS];

    t_mip_word pending_mips [$];
    int errors = 0;
    int n_texels = 0;
    int n_mips = 0;
    int cycles = 0;
    int hold_off = 0;
    int unsigned sink_gap = 0;
    bit got_word = 1'b0;
    bit random_pace = 1'b0;

    task automatic clear_boxes();
        pos_col = 0;
        pos_row = 0;
        for (int i = 0; i < ACC_SLOTS; i++) begin
            acc_r[i] = '0; acc_g[i] = '0; acc_b[i] = '0; acc_a[i] = '0;
        end
    endtask

    task automatic predict_mips(input logic [7:0] r, g, b, a);
        int unsigned wd, ht, lvls, base, w, h, m, x, y, idx, sh, first;
        t_mip_word mw;
        wd = (box_w > BOX_MAX) ? BOX_MAX : box_w;
        ht = (box_h > BOX_MAX) ? BOX_MAX : box_h;
        lvls = (n_levels > LVL_MAX) ? LVL_MAX : n_levels;
        base = 0;
        first = pending_mips.size();
        if (wd == 0 || ht == 0) return;
        for (int unsigned lv = 0; lv < lvls; lv++) begin
            w = wd >> lv;
            h = ht >> lv;
            m = (1 << lv) - 1;
            x = pos_col >> lv;
            y = pos_row >> lv;
            if (w == 0 || h == 0) break;
            if (x < w && y < h) begin
                idx = base + x;
                if (idx >= ACC_SLOTS) break;
                acc_r[idx] += r; acc_g[idx] += g; acc_b[idx] += b; acc_a[idx] += a;
                if ((pos_col & m) == m && (pos_row & m) == m) begin
                    sh = 2 * lv;
                    mw.level = 4'(lv);
                    mw.dest_x = 11'((box_l >> lv) + x);
                    mw.dest_y = 11'((box_t >> lv) + y);
                    mw.avg_red = 8'(acc_r[idx] >> sh);
                    mw.avg_green = 8'(acc_g[idx] >> sh);
                    mw.avg_blue = 8'(acc_b[idx] >> sh);
                    mw.avg_alpha = 8'(acc_a[idx] >> sh);
                    mw.last = 1'b0;
                    acc_r[idx] = '0; acc_g[idx] = '0; acc_b[idx] = '0; acc_a[idx] = '0;
                    pending_mips.push_back(mw);
                end
            end
            base += BOX_MAX >> lv;
        end
        if (pos_col + 1 >= wd) begin
            pos_col = 0;
            if (pos_row + 1 >= ht) pos_row = 0;
            else pos_row++;
        end else begin
            pos_col++;
        end
        if (pending_mips.size() > first) pending_mips[$].last = 1'b1;
    endtask

    // register writes only when the block is idle
    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  box_w = 12'(value);
            CFG_HEIGHT: box_h = 12'(value);
            CFG_LEFT:   box_l = 11'(value);
            CFG_TOP:    box_t = 11'(value);
            CFG_LEVELS: n_levels = 4'(value);
            default: ;
        endcase
        if (idx <= CFG_LEVELS) clear_boxes();
    endtask

    // called at a falling edge; drops valid, then waits for every result
    task automatic drain();
        texel_ch.valid <= 1'b0;
        while (pending_mips.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_box(input int unsigned w, h, l, t, lv);
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_TOP, t);
        write_reg(CFG_LEVELS, lv);
    endtask

    // texel sender, called at a falling edge; valid stays up for a following word
    task automatic send_texel(input logic [7:0] r, g, b, a);
        int unsigned gap;
        gap = random_pace ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            texel_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        texel_ch.valid <= 1'b1;
        texel_ch.red <= r;
        texel_ch.green <= g;
        texel_ch.blue <= b;
        texel_ch.alpha <= a;
        @(posedge i_clk);
        while (!texel_ch.ready) @(posedge i_clk);
        predict_mips(r, g, b, a);
        n_texels++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_texel($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // result sink
    initial begin
        mip_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (got_word) begin
                got_word = 1'b0;
                sink_gap = random_pace ? $urandom_range(0, 4) : 0;
            end
            if (hold_off > 0) begin
                hold_off--;
                mip_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                mip_ch.ready <= 1'b0;
            end else begin
                mip_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_mip_word got, want;
        cycles <= cycles + 1;
        if (i_rst_n && mip_ch.valid && mip_ch.ready) begin
            got = '{mip_ch.level, mip_ch.dest_x, mip_ch.dest_y, mip_ch.avg_red,
                    mip_ch.avg_green, mip_ch.avg_blue, mip_ch.avg_alpha, mip_ch.last};
            n_mips <= n_mips + 1;
            got_word = 1'b1;
            if (pending_mips.size() == 0) begin
                $display("%0t: unexpected word, actual %p", $realtime, got);
                errors <= errors + 1;
            end else begin
                want = pending_mips.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_extremes();
        set_box(4, 4, 2047, 2047, 3);
        send_texel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_texel(8'h00, 8'h00, 8'h00, 8'h00);
        send_texel(8'hAA, 8'h55, 8'h0F, 8'hF0);
        send_texel(8'h55, 8'hAA, 8'hF0, 8'h0F);
        send_random(12);
        send_random(3);
    endtask

    task automatic test_odd_and_clamped();
        set_box(3, 1, 5, 9, 12);
        send_random(4);
        set_box(1, 1, 0, 0, 1);
        send_random(2);
        set_box(4095, 2, 100, 3, 15);
        send_random(6);
    endtask

    task automatic test_degenerate();
        set_box(0, 3, 0, 0, 2);
        send_random(3);
        drain();
        set_box(2, 2, 1, 1, 0);
        send_random(5);
        drain();
        write_reg(CFG_LEVELS, 2);
        send_random(3);
        drain();
        write_reg(t_cfg_idx'(3'd7), 123);
        send_random(3);
    endtask

    task automatic test_random_boxes();
        int unsigned w, h;
        random_pace = 1'b1;
        for (int k = 0; k < 9; k++) begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 6);
            if (k == 3) w = 4094 + $urandom_range(0, 1);
            set_box(w, h, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 15));
            send_random((k == 3) ? 10 : w * h * $urandom_range(1, 2) + $urandom_range(0, 3));
        end
    endtask

    task automatic test_backpressure();
        set_box(8, 8, 7, 3, 4);
        hold_off = 300;
        send_random(64);
        drain();
        send_random(32);
        drain();
        send_random(16);
    endtask

    initial begin
        texel_ch.valid = 1'b0;
        texel_ch.red = '0;
        texel_ch.green = '0;
        texel_ch.blue = '0;
        texel_ch.alpha = '0;
        clear_boxes();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_odd_and_clamped();
        test_degenerate();
        test_random_boxes();
        test_backpressure();
        drain();
        $display("Covered %0d texels and %0d mip words over directed, clamped,",
                 n_texels, n_mips);
        $display("degenerate and random box shapes with output stalls.");
        if (errors == 0 && pending_mips.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
